FILE: hw/rtl/rte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rte_pkg;

   // Widest entry address the table supports.
   localparam int ADDR_MAX_W = 8;

   // Operation codes.
   localparam logic [2:0] OP_CREATE = 3'd0;
   localparam logic [2:0] OP_SEARCH = 3'd1;
   localparam logic [2:0] OP_READ   = 3'd2;
   localparam logic [2:0] OP_UPDATE = 3'd3;
   localparam logic [2:0] OP_DELETE = 3'd4;

   // One operation word on the request channel.
   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  index;
      logic [7:0]  dest_addr;
      logic [31:0] dest_seq;
      logic        route_invalid;
      logic [7:0]  hop_count;
      logic [7:0]  next_hop;
      logic [63:0] lifetime;
      logic [63:0] stamp;
   } req_word_type;

   // One result word on the response channel.
   typedef struct packed {
      logic        ok;
      logic [7:0]  entry_index;
      logic [7:0]  out_dest_addr;
      logic [31:0] out_dest_seq;
      logic        out_invalid;
      logic [7:0]  out_hop_count;
      logic [7:0]  out_next_hop;
      logic [63:0] out_lifetime;
      logic [63:0] out_stamp;
   } rsp_word_type;

   // One stored route.
   typedef struct packed {
      logic [7:0]  dest_addr;
      logic [31:0] dest_seq;
      logic        route_invalid;
      logic [7:0]  hop_count;
      logic [7:0]  next_hop;
      logic [63:0] lifetime;
      logic [63:0] stamp;
   } route_type;

   // Access command from the sequencer to the route memory.
   typedef struct packed {
      logic                  wr_en;
      logic [ADDR_MAX_W-1:0] wr_addr;
      route_type             wr_route;
      logic                  rd_en;
      logic [ADDR_MAX_W-1:0] rd_addr;
   } store_cmd_type;

endpackage

`default_nettype wire

FILE: hw/rtl/rte_store.sv
`timescale 1ns / 1ps
`default_nettype none

module rte_store #(
   parameter int ENTRIES = 256
) (
   input  wire logic                   clock,
   input  wire rte_pkg::store_cmd_type cmd,
   output rte_pkg::route_type          rd_route
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   rte_pkg::route_type mem [ENTRIES];
   rte_pkg::route_type rd_route_ff;

   // One write port and one read port with registered read data.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_route;
      end
      if (cmd.rd_en) begin
         rd_route_ff <= mem[cmd.rd_addr[AW-1:0]];
      end
   end

   assign rd_route = rd_route_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/rte_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rte_ctrl #(
   parameter int ENTRIES = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire rte_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rte_pkg::rsp_word_type      rsp_word,
   output rte_pkg::store_cmd_type     store_cmd,
   input  wire rte_pkg::route_type    rd_route
);

   localparam int CW = $clog2(ENTRIES + 1);
   localparam int MW = rte_pkg::ADDR_MAX_W;
   localparam int XW = rte_pkg::ADDR_MAX_W + 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [CW-1:0]         entry_count_ff, entry_count_in;
   logic [CW-1:0]         scan_ff, scan_in;
   logic [7:0]            key_ff, key_in;
   rte_pkg::rsp_word_type res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rte_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic               accept;
   logic               in_range;
   logic               room;
   logic [CW-1:0]      scan_nxt;
   logic               scan_last;
   logic               key_hit;
   rte_pkg::route_type new_route;
   rte_pkg::route_type blank_route;

   // Handshake and the checks shared by several operations.
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign in_range  = {1'b0, req_word.index} < XW'(entry_count_ff);
   assign room      = entry_count_ff < CW'(ENTRIES);
   assign scan_nxt  = scan_ff + CW'(1);
   assign scan_last = (scan_nxt == entry_count_ff);
   assign key_hit   = (rd_route.dest_addr == key_ff);

   // Routes built from the request word.
   always_comb begin
      new_route.dest_addr     = req_word.dest_addr;
      new_route.dest_seq      = req_word.dest_seq;
      new_route.route_invalid = req_word.route_invalid;
      new_route.hop_count     = req_word.hop_count;
      new_route.next_hop      = req_word.next_hop;
      new_route.lifetime      = req_word.lifetime;
      new_route.stamp         = req_word.stamp;
      blank_route             = '0;
      blank_route.stamp       = req_word.stamp;
   end

   // Sequencer: one operation at a time, search walks the table one entry a cycle.
   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      scan_in        = scan_ff;
      key_in         = key_ff;
      res_in         = res_ff;
      store_cmd      = '0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_word_in    = rsp_word_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in   = req_word.dest_addr;
               res_in   = '0;
               state_in = ST_FINISH;
               unique case (req_word.op)
                  rte_pkg::OP_CREATE: begin
                     if (room) begin
                        store_cmd.wr_en    = 1'b1;
                        store_cmd.wr_addr  = MW'(entry_count_ff);
                        store_cmd.wr_route = new_route;
                        res_in.ok          = 1'b1;
                        res_in.entry_index = 8'(entry_count_ff);
                        entry_count_in     = entry_count_ff + CW'(1);
                     end
                  end
                  rte_pkg::OP_SEARCH: begin
                     if (entry_count_ff != '0) begin
                        store_cmd.rd_en   = 1'b1;
                        store_cmd.rd_addr = '0;
                        scan_in           = '0;
                        state_in          = ST_SCAN;
                     end
                  end
                  rte_pkg::OP_READ: begin
                     if (in_range) begin
                        store_cmd.rd_en   = 1'b1;
                        store_cmd.rd_addr = req_word.index;
                        state_in          = ST_READ;
                     end else begin
                        res_in.out_stamp = req_word.stamp;
                     end
                  end
                  rte_pkg::OP_UPDATE: begin
                     if (in_range) begin
                        store_cmd.wr_en    = 1'b1;
                        store_cmd.wr_addr  = req_word.index;
                        store_cmd.wr_route = new_route;
                        res_in.ok          = 1'b1;
                     end
                  end
                  rte_pkg::OP_DELETE: begin
                     if (in_range) begin
                        store_cmd.wr_en    = 1'b1;
                        store_cmd.wr_addr  = req_word.index;
                        store_cmd.wr_route = blank_route;
                        res_in.ok          = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // The read data belongs to entry scan_ff; the next address goes out meanwhile.
            if (key_hit) begin
               res_in.ok          = 1'b1;
               res_in.entry_index = 8'(scan_ff);
               state_in           = ST_FINISH;
            end else if (scan_last) begin
               state_in = ST_FINISH;
            end else begin
               store_cmd.rd_en   = 1'b1;
               store_cmd.rd_addr = MW'(scan_nxt);
               scan_in           = scan_nxt;
            end
         end
         ST_READ: begin
            res_in.ok            = 1'b1;
            res_in.out_dest_addr = rd_route.dest_addr;
            res_in.out_dest_seq  = rd_route.dest_seq;
            res_in.out_invalid   = rd_route.route_invalid;
            res_in.out_hop_count = rd_route.hop_count;
            res_in.out_next_hop  = rd_route.next_hop;
            res_in.out_lifetime  = rd_route.lifetime;
            res_in.out_stamp     = rd_route.stamp;
            state_in             = ST_FINISH;
         end
         ST_FINISH: begin
            // Move the result into the output register once it is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      key_ff      <= key_in;
      res_ff      <= res_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // The fill count never passes the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CW'(ENTRIES))
      else $error("entry count exceeds table size");

   // A scan only looks at entries below the fill count.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_ff < entry_count_ff))
      else $error("search scan beyond fill count");

   // A new result appears only out of the finish state.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result word raised outside finish");

   // The fill count moves only after an accepted create.
   a_count_move: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (entry_count_ff != $past(entry_count_ff)))
      |-> $past(accept && (req_word.op == rte_pkg::OP_CREATE)))
      else $error("entry count changed without create");

endmodule

`default_nettype wire

FILE: hw/rtl/route_table_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel    Ports                            Word type
// request    req_valid, req_stall, req_word   rte_pkg::req_word_type
// response   rsp_valid, rsp_stall, rsp_word   rte_pkg::rsp_word_type
//
// Create, update, delete and unused codes go from accept straight to the finish state.
// An in-range read passes through the read state for the registered memory read.
// Search walks the table in the scan state: the single route memory read
// port feeds one stored destination a cycle into the key compare.
// Reset empties the table at once; stored routes need no clearing.
// A waiting response word does not block the next request, but a finished operation
// holds in the sequencer until the response register is free.

module route_table_engine_core #(
   parameter int ENTRIES = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire rte_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rte_pkg::rsp_word_type      rsp_word
);

   rte_pkg::store_cmd_type store_cmd;
   rte_pkg::route_type     rd_route;

   // Sequencer with the shared key compare.
   rte_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .store_cmd (store_cmd),
      .rd_route  (rd_route)
   );

   // Route memory.
   rte_store #(
      .ENTRIES (ENTRIES)
   ) u_store (
      .clock    (clock),
      .cmd      (store_cmd),
      .rd_route (rd_route)
   );

endmodule

`default_nettype wire

FILE: tb/route_table_engine_core_tb.sv
`timescale 1ns / 1ps

module route_table_engine_core_tb;

   localparam int TABLE_DEPTH    = 256;
   localparam int CLOCK_PERIOD   = 12;
   localparam int RANDOM_OPS     = 1175;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int IDLE_LIMIT     = 4000;
   localparam int DRAIN_CYCLES   = 300;
   localparam int REPORT_LIMIT   = 10;

   // Codes the block leaves unused; it answers them with an all-zero word.
   localparam logic [2:0] OP_SPARE_LO  = 3'd5;
   localparam logic [2:0] OP_SPARE_MID = 3'd6;
   localparam logic [2:0] OP_SPARE_HI  = 3'd7;

   localparam logic [63:0] ONES64 = '1;

   typedef struct {
      rte_pkg::req_word_type word;
      bit                    has_fixed;
      rte_pkg::rsp_word_type fixed;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   rte_pkg::req_word_type req_word = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rte_pkg::rsp_word_type rsp_word;

   // Typed-in expectation that travels with the word on the request port.
   bit                    drv_fixed = 1'b0;
   rte_pkg::rsp_word_type drv_fixed_word = '0;

   // Shadow copy of the route table.
   rte_pkg::route_type route_mem [TABLE_DEPTH];
   int unsigned        route_fill;

   rte_pkg::rsp_word_type route_expect_q [$];
   stim_row_type          directed_rows [$];

   int mismatch_count;
   int idle_cycles;
   int holdoff_asked;
   int holdoff_done;
   bit sender_calm;
   int op_tally [8];
   int search_hits;
   int refused_creates;
   int out_of_range_ops;

   route_table_engine_core #(
      .ENTRIES(TABLE_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Apply one operation to the shadow table and return the word it should produce.
   function automatic rte_pkg::rsp_word_type apply_route_op(input rte_pkg::req_word_type w);
      rte_pkg::rsp_word_type r;
      rte_pkg::route_type    fresh;
      rte_pkg::route_type    blank;
      bit                    in_range;
      bit                    found;
      r = '0;
      fresh.dest_addr     = w.dest_addr;
      fresh.dest_seq      = w.dest_seq;
      fresh.route_invalid = w.route_invalid;
      fresh.hop_count     = w.hop_count;
      fresh.next_hop      = w.next_hop;
      fresh.lifetime      = w.lifetime;
      fresh.stamp         = w.stamp;
      blank = '0;
      blank.stamp = w.stamp;
      in_range = (w.index < route_fill);
      found = 1'b0;
      case (w.op)
         rte_pkg::OP_CREATE: begin
            if (route_fill < TABLE_DEPTH) begin
               route_mem[route_fill] = fresh;
               r.ok = 1'b1;
               r.entry_index = 8'(route_fill);
               route_fill++;
            end
         end
         rte_pkg::OP_SEARCH: begin
            // The lowest matching index below the fill count wins.
            for (int i = 0; i < route_fill; i++) begin
               if (!found && route_mem[i].dest_addr == w.dest_addr) begin
                  found = 1'b1;
                  r.ok = 1'b1;
                  r.entry_index = 8'(i);
               end
            end
         end
         rte_pkg::OP_READ: begin
            if (in_range) begin
               r.ok            = 1'b1;
               r.out_dest_addr = route_mem[w.index].dest_addr;
               r.out_dest_seq  = route_mem[w.index].dest_seq;
               r.out_invalid   = route_mem[w.index].route_invalid;
               r.out_hop_count = route_mem[w.index].hop_count;
               r.out_next_hop  = route_mem[w.index].next_hop;
               r.out_lifetime  = route_mem[w.index].lifetime;
               r.out_stamp     = route_mem[w.index].stamp;
            end else begin
               r.out_stamp = w.stamp;
            end
         end
         rte_pkg::OP_UPDATE: begin
            if (in_range) begin
               route_mem[w.index] = fresh;
               r.ok = 1'b1;
            end
         end
         rte_pkg::OP_DELETE: begin
            // The count stays; the entry becomes a blank route with destination zero.
            if (in_range) begin
               route_mem[w.index] = blank;
               r.ok = 1'b1;
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic rte_pkg::req_word_type route_req(
         input logic [2:0] op, input logic [7:0] idx, input logic [7:0] dest,
         input logic [31:0] seq, input logic inv, input logic [7:0] hops,
         input logic [7:0] via, input logic [63:0] life, input logic [63:0] stamp);
      rte_pkg::req_word_type w;
      w.op            = op;
      w.index         = idx;
      w.dest_addr     = dest;
      w.dest_seq      = seq;
      w.route_invalid = inv;
      w.hop_count     = hops;
      w.next_hop      = via;
      w.lifetime      = life;
      w.stamp         = stamp;
      return w;
   endfunction

   function automatic rte_pkg::rsp_word_type status_word(input logic ok,
                                                         input logic [7:0] idx);
      rte_pkg::rsp_word_type r;
      r = '0;
      r.ok = ok;
      r.entry_index = idx;
      return r;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap_len();
      if ($urandom_range(0, 99) < 85) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Random operation, biased toward indexes in range and destinations that already exist.
   function automatic rte_pkg::req_word_type random_route_op();
      rte_pkg::req_word_type w;
      int                    pick;
      w.dest_seq      = $urandom;
      w.lifetime      = {$urandom, $urandom};
      w.stamp         = {$urandom, $urandom};
      w.route_invalid = 1'($urandom_range(0, 1));
      w.hop_count     = 8'($urandom_range(0, 255));
      w.next_hop      = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 60) begin
         w.dest_addr = 8'($urandom_range(0, 15));
      end else begin
         w.dest_addr = 8'($urandom_range(0, 255));
      end
      if (route_fill > 0 && $urandom_range(0, 99) < 75) begin
         w.index = 8'($urandom_range(0, route_fill - 1));
      end else begin
         w.index = 8'($urandom_range(0, 255));
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         w.op = rte_pkg::OP_CREATE;
      end else if (pick < 50) begin
         w.op = rte_pkg::OP_SEARCH;
         if (route_fill > 0 && $urandom_range(0, 99) < 70) begin
            w.dest_addr = route_mem[8'($urandom_range(0, route_fill - 1))].dest_addr;
         end
      end else if (pick < 70) begin
         w.op = rte_pkg::OP_READ;
      end else if (pick < 85) begin
         w.op = rte_pkg::OP_UPDATE;
      end else if (pick < 97) begin
         w.op = rte_pkg::OP_DELETE;
      end else begin
         w.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      end
      return w;
   endfunction

   task automatic add_row(input rte_pkg::req_word_type w, input bit fixed,
                          input rte_pkg::rsp_word_type fx);
      stim_row_type row;
      row.word = w;
      row.has_fixed = fixed;
      row.fixed = fx;
      directed_rows.push_back(row);
   endtask

   // Offer one word after an optional gap and hold it until the block takes it.
   task automatic send_route_op(input rte_pkg::req_word_type w, input bit fixed,
                                input rte_pkg::rsp_word_type fx);
      int gap;
      gap = 0;
      if (!sender_calm && $urandom_range(0, 99) < 30) begin
         gap = pick_gap_len();
      end
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_word       <= w;
      drv_fixed      <= fixed;
      drv_fixed_word <= fx;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   task automatic log_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t ERROR: %s expected %h, got %h", $realtime, what, want, got);
      end
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         log_mismatch(what, want, got);
      end
   endtask

   // Watch both ports: predict on each accepted request, check each accepted response.
   always @(posedge clock) begin : route_monitor
      rte_pkg::rsp_word_type want;
      rte_pkg::rsp_word_type predicted;
      bit                    moved;
      moved = 1'b0;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         moved = 1'b1;
         if (route_expect_q.size() == 0) begin
            log_mismatch("unexpected response word, ok/entry_index",
                         64'(rsp_word.ok), 64'(rsp_word.entry_index));
         end else begin
            want = route_expect_q.pop_front();
            check_field("ok", 64'(want.ok), 64'(rsp_word.ok));
            check_field("entry_index", 64'(want.entry_index), 64'(rsp_word.entry_index));
            check_field("out_dest_addr", 64'(want.out_dest_addr),
                        64'(rsp_word.out_dest_addr));
            check_field("out_dest_seq", 64'(want.out_dest_seq), 64'(rsp_word.out_dest_seq));
            check_field("out_invalid", 64'(want.out_invalid), 64'(rsp_word.out_invalid));
            check_field("out_hop_count", 64'(want.out_hop_count),
                        64'(rsp_word.out_hop_count));
            check_field("out_next_hop", 64'(want.out_next_hop), 64'(rsp_word.out_next_hop));
            check_field("out_lifetime", want.out_lifetime, rsp_word.out_lifetime);
            check_field("out_stamp", want.out_stamp, rsp_word.out_stamp);
         end
      end
      if (!reset && req_valid === 1'b1 && req_stall === 1'b0) begin
         moved = 1'b1;
         predicted = apply_route_op(req_word);
         op_tally[req_word.op]++;
         if (req_word.op == rte_pkg::OP_SEARCH && predicted.ok) begin
            search_hits++;
         end
         if (req_word.op == rte_pkg::OP_CREATE && !predicted.ok) begin
            refused_creates++;
         end
         if ((req_word.op == rte_pkg::OP_READ || req_word.op == rte_pkg::OP_UPDATE ||
              req_word.op == rte_pkg::OP_DELETE) && !predicted.ok) begin
            out_of_range_ops++;
         end
         route_expect_q.push_back(drv_fixed ? drv_fixed_word : predicted);
      end
      // A long run without any word moving on either port means the block hung.
      if (moved) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Response back-pressure: calm stretches, random stalls, and a long hold-off on request.
   initial begin : rsp_backpressure
      int mode_left;
      int stall_left;
      bit stall_mode;
      mode_left = 0;
      stall_left = 0;
      stall_mode = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_asked != holdoff_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(negedge clock);
            holdoff_done++;
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = ($urandom_range(0, 2) != 0);
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (stall_mode && $urandom_range(0, 99) < 30) begin
               stall_left = pick_gap_len() - 1;
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   initial begin : stimulus
      rte_pkg::rsp_word_type fx;
      rte_pkg::req_word_type w;
      int                    useful_sent;
      int                    spare_total;

      route_fill = 0;
      sender_calm = 1'b1;
      foreach (route_mem[i]) route_mem[i] = '0;

      // Empty table: every index-based op is out of range and search misses.
      add_row(route_req(rte_pkg::OP_SEARCH, 8'h00, 8'h00, '0, 1'b0, '0, '0, '0, '0),
              1'b1, status_word(1'b0, 8'h00));
      fx = status_word(1'b0, 8'h00);
      fx.out_stamp = ONES64;
      add_row(route_req(rte_pkg::OP_READ, 8'h00, 8'h00, '0, 1'b0, '0, '0, '0, ONES64),
              1'b1, fx);
      add_row(route_req(rte_pkg::OP_UPDATE, 8'hFF, 8'h12, 32'h1, 1'b1, 8'h3, 8'h4,
                        64'h5, 64'h6), 1'b1, status_word(1'b0, 8'h00));
      add_row(route_req(rte_pkg::OP_DELETE, 8'h00, 8'h00, '0, 1'b0, '0, '0, '0, 64'h77),
              1'b1, status_word(1'b0, 8'h00));

      // Two creates at the field extremes, then read them back.
      add_row(route_req(rte_pkg::OP_CREATE, 8'h00, 8'h00, '0, 1'b0, '0, '0, '0, '0),
              1'b1, status_word(1'b1, 8'h00));
      add_row(route_req(rte_pkg::OP_CREATE, 8'hFF, 8'hFF, '1, 1'b1, 8'hFF, 8'hFF,
                        ONES64, ONES64), 1'b1, status_word(1'b1, 8'h01));
      fx = status_word(1'b1, 8'h00);
      fx.out_dest_addr = 8'hFF;
      fx.out_dest_seq  = '1;
      fx.out_invalid   = 1'b1;
      fx.out_hop_count = 8'hFF;
      fx.out_next_hop  = 8'hFF;
      fx.out_lifetime  = ONES64;
      fx.out_stamp     = ONES64;
      add_row(route_req(rte_pkg::OP_READ, 8'h01, 8'h00, '0, 1'b0, '0, '0, '0, 64'h5),
              1'b1, fx);
      add_row(route_req(rte_pkg::OP_READ, 8'h00, 8'hFF, '1, 1'b1, 8'hFF, 8'hFF,
                        ONES64, ONES64), 1'b1, status_word(1'b1, 8'h00));
      add_row(route_req(rte_pkg::OP_SEARCH, 8'h00, 8'hFF, '0, 1'b0, '0, '0, '0, '0),
              1'b1, status_word(1'b1, 8'h01));
      add_row(route_req(rte_pkg::OP_SEARCH, 8'hFF, 8'h00, '0, 1'b0, '0, '0, '0, '0),
              1'b1, status_word(1'b1, 8'h00));
      fx = status_word(1'b0, 8'h00);
      fx.out_stamp = 64'h0123_4567_89AB_CDEF;
      add_row(route_req(rte_pkg::OP_READ, 8'h02, 8'h00, '0, 1'b0, '0, '0, '0,
                        64'h0123_4567_89AB_CDEF), 1'b1, fx);

      // Update, delete and search interplay, including a hit on a deleted entry.
      add_row(route_req(rte_pkg::OP_CREATE, 8'h00, 8'h5A, 32'hDEAD_BEEF, 1'b0, 8'd3, 8'h21,
                        64'd900, 64'd1000), 1'b0, '0);
      add_row(route_req(rte_pkg::OP_UPDATE, 8'h00, 8'h5A, 32'h1234_5678, 1'b1, 8'd7, 8'h44,
                        64'd60, 64'd1001), 1'b0, '0);
      add_row(route_req(rte_pkg::OP_SEARCH, 8'h00, 8'h5A, '0, 1'b0, '0, '0, '0, '0),
              1'b0, '0);
      add_row(route_req(rte_pkg::OP_DELETE, 8'h00, 8'h00, '0, 1'b0, '0, '0, '0, 64'd2002),
              1'b0, '0);
      add_row(route_req(rte_pkg::OP_READ, 8'h00, 8'h00, '0, 1'b0, '0, '0, '0, 64'd2003),
              1'b0, '0);
      add_row(route_req(rte_pkg::OP_SEARCH, 8'h00, 8'h00, '0, 1'b0, '0, '0, '0, '0),
              1'b0, '0);
      add_row(route_req(rte_pkg::OP_DELETE, 8'h01, 8'h00, '0, 1'b0, '0, '0, '0, 64'd2004),
              1'b0, '0);
      add_row(route_req(rte_pkg::OP_SEARCH, 8'h00, 8'hFF, '0, 1'b0, '0, '0, '0, '0),
              1'b0, '0);
      add_row(route_req(rte_pkg::OP_UPDATE, 8'h02, 8'hA5, 32'h0F0F_0F0F, 1'b1, 8'd1, 8'h80,
                        64'h8000_0000_0000_0000, 64'd3000), 1'b0, '0);
      add_row(route_req(rte_pkg::OP_SEARCH, 8'h00, 8'h5A, '0, 1'b0, '0, '0, '0, '0),
              1'b0, '0);
      add_row(route_req(rte_pkg::OP_UPDATE, 8'h03, 8'h11, 32'h2, 1'b0, 8'd2, 8'h2,
                        64'd2, 64'd2), 1'b1, status_word(1'b0, 8'h00));

      // Unused codes, with every field set or every field clear, are answered with an all-zero word.
      add_row(route_req(OP_SPARE_LO, 8'hFF, 8'hFF, '1, 1'b1, 8'hFF, 8'hFF, ONES64, ONES64),
              1'b1, '0);
      add_row(route_req(OP_SPARE_MID, 8'hFF, 8'hFF, '1, 1'b1, 8'hFF, 8'hFF, ONES64, ONES64),
              1'b1, '0);
      add_row(route_req(OP_SPARE_HI, 8'h00, 8'h00, '0, 1'b0, '0, '0, '0, '0), 1'b1, '0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_route_op(directed_rows[i].word, directed_rows[i].has_fixed,
                       directed_rows[i].fixed);
      end

      // Random part; words with unused codes do not count toward the total.
      useful_sent = 0;
      while (useful_sent < RANDOM_OPS) begin
         if (useful_sent % 64 == 0) begin
            sender_calm = ($urandom_range(0, 2) == 0);
         end
         if (useful_sent == 300) begin
            // Hold off the response side while requests keep coming.
            holdoff_asked++;
         end
         if (useful_sent == 700) begin
            // Let the block drain completely before going on.
            @(negedge clock);
            req_valid <= 1'b0;
            while (route_expect_q.size() != 0) @(posedge clock);
         end
         w = random_route_op();
         send_route_op(w, 1'b0, '0);
         if (w.op <= rte_pkg::OP_DELETE) begin
            useful_sent++;
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (route_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      spare_total = op_tally[OP_SPARE_LO] + op_tally[OP_SPARE_MID] + op_tally[OP_SPARE_HI];
      $display("Run covered %0d create, %0d search, %0d read, %0d update, %0d delete,",
               op_tally[rte_pkg::OP_CREATE], op_tally[rte_pkg::OP_SEARCH],
               op_tally[rte_pkg::OP_READ], op_tally[rte_pkg::OP_UPDATE],
               op_tally[rte_pkg::OP_DELETE]);
      $display("%0d unused; search hits %0d, creates on a full table %0d, out-of-range %0d.",
               spare_total, search_hits, refused_creates, out_of_range_ops);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
